/* rtl/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and codes of the periodic timer table
// Request and result codes, the slot entry kept in memory, the result record.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int MAX_RESULTS   = 8;
	localparam int FIRE_W        = 4;
	localparam int STEP_W        = 16;
	localparam int HANDLE_W      = 8;
	localparam int PERIOD_W      = 32;
	localparam int REM_W         = 33;
	localparam int COUNT_W       = 4;
	localparam logic [STEP_W-1:0] STEP_RESET = 16'd1;

	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [1:0] KIND_FIRED  = 2'd0;
	localparam logic [1:0] KIND_ADDED  = 2'd1;
	localparam logic [1:0] KIND_FULL   = 2'd2;
	localparam logic [1:0] KIND_REMOVE = 2'd3;

	typedef struct packed {
		logic [HANDLE_W-1:0]     handle;
		logic [PERIOD_W-1:0]     period;
		logic signed [REM_W-1:0] remaining;
	} slot_entry_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [HANDLE_W-1:0] handle;
		logic [COUNT_W-1:0]  count;
	} rsp_t;

endpackage

/* rtl/periodic_timer_table.sv */
// ----------------------------------------------------------------------------
// periodic_timer_table: table of periodic timers
// Add, remove and tick requests over a slot memory scanned one slot a cycle unless a stalled output holds the scan.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+---------------------
//  in      | req_type, handle_id, period               | in_valid / in_stall
//  out     | kind, fired_handle, removed_count, last   | out_valid / out_stall
//  cfg     | cfg_wr_data (tick_step)                   | cfg_wr_en, no wait
//
//  Add: its beat is loaded into the output register once the output is free.
//  Tick and remove: one pass over the slot memory, one slot a cycle through a
//  read / modify / write pipe while a stalled output does not hold the scan.
//  The next request is taken once the final beat, if any, sits in the output register.
//  A stalled output holds the scan when a fired beat is found after the first.
//  Reset clears the active bits at once; no clearing pass.
//
module periodic_timer_table
	import ptt_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic [HANDLE_W-1:0]  handle_id,
	input  logic [PERIOD_W-1:0]  period,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           kind,
	output logic [HANDLE_W-1:0]  fired_handle,
	output logic [COUNT_W-1:0]   removed_count,
	output logic                 last,
	input  logic                 cfg_wr_en,
	input  logic [STEP_W-1:0]    cfg_wr_data
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	slot_entry_t slot_mem [NUM_SLOTS];

	logic [1:0]           state_q;
	logic [STEP_W-1:0]    step_q;
	logic [NUM_SLOTS-1:0] active_q;
	logic [1:0]           op_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic [CNT_W-1:0]     rd_idx_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [FIRE_W-1:0]    fired_n_q;
	logic                 s1_vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	slot_entry_t          rd_data_s1;
	logic                 pend_vld_q;
	rsp_t                 pend_q;
	logic                 out_vld_q;
	rsp_t                 out_q;
	logic                 out_last_q;

	logic                 in_acc;
	logic                 out_free;
	logic [IDX_W-1:0]     free_idx;
	logic                 table_full;
	logic                 add_wr;
	logic                 hit_tick;
	logic                 hit_rm;
	logic signed [REM_W-1:0] rem_new;
	logic                 due;
	logic                 emit;
	logic                 s1_hold;
	logic                 push_out;
	logic                 flush_out;
	logic                 rd_en;
	logic                 scan_done;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	slot_entry_t          wr_data;
	logic [6:0]           cnt_ext;
	logic [COUNT_W-1:0]   cnt_sat;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_vld_q || !out_stall;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end
	assign table_full = &active_q;
	assign add_wr     = in_acc && (req_type == REQ_ADD) && !table_full;

	// stage 1: modify the entry registered by the read stage
	assign hit_tick = s1_vld_s1 && (op_q == REQ_TICK) && active_q[idx_s1];
	assign hit_rm   = s1_vld_s1 && (op_q == REQ_REMOVE) && active_q[idx_s1]
		&& (rd_data_s1.handle == handle_q);
	assign rem_new  = rd_data_s1.remaining - $signed({{(REM_W - STEP_W){1'b0}}, step_q});
	assign due      = rem_new[REM_W-1] || (rem_new == '0);
	assign emit     = hit_tick && due && (fired_n_q < FIRE_W'(MAX_RESULTS));
	assign s1_hold  = emit && pend_vld_q && !out_free;
	assign push_out = emit && pend_vld_q && out_free;
	assign flush_out = (state_q == ST_FLUSH) && out_free;

	assign rd_en     = (state_q == ST_SCAN) && !s1_hold && (rd_idx_q != CNT_W'(NUM_SLOTS));
	assign scan_done = (state_q == ST_SCAN) && !s1_vld_s1 && (rd_idx_q == CNT_W'(NUM_SLOTS));

	assign cnt_ext = 7'(cnt_q);
	assign cnt_sat = (cnt_ext > 7'd15) ? 4'd15 : cnt_ext[COUNT_W-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = rd_data_s1;
		if (add_wr) begin
			wr_en             = 1'b1;
			wr_addr           = free_idx;
			wr_data.handle    = handle_id;
			wr_data.period    = period;
			wr_data.remaining = $signed({1'b0, period});
		end else if (hit_tick && !s1_hold) begin
			wr_en             = 1'b1;
			wr_data.remaining = due ? $signed({1'b0, rd_data_s1.period}) : rem_new;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= slot_mem[rd_idx_q[IDX_W-1:0]];
			idx_s1     <= rd_idx_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_wr_en) begin
			step_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			active_q   <= '0;
			rd_idx_q   <= '0;
			cnt_q      <= '0;
			fired_n_q  <= '0;
			s1_vld_s1  <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						rd_idx_q  <= '0;
						cnt_q     <= '0;
						fired_n_q <= '0;
						s1_vld_s1 <= 1'b0;
						if (req_type == REQ_ADD) begin
							pend_vld_q <= 1'b1;
							state_q    <= ST_FLUSH;
							if (!table_full) begin
								active_q[free_idx] <= 1'b1;
							end
						end else if (req_type == REQ_TICK || req_type == REQ_REMOVE) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit_rm) begin
						active_q[idx_s1] <= 1'b0;
						cnt_q            <= cnt_q + 1'b1;
					end
					if (emit && !s1_hold) begin
						fired_n_q  <= fired_n_q + 1'b1;
						pend_vld_q <= 1'b1;
					end
					if (!s1_hold) begin
						s1_vld_s1 <= rd_en;
						if (rd_en) begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					if (scan_done) begin
						if (op_q == REQ_REMOVE) begin
							pend_vld_q <= 1'b1;
							state_q    <= ST_FLUSH;
						end else if (pend_vld_q) begin
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (flush_out) begin
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (push_out || flush_out) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q     <= req_type;
			handle_q <= handle_id;
			if (req_type == REQ_ADD) begin
				pend_q.kind   <= table_full ? KIND_FULL : KIND_ADDED;
				pend_q.handle <= handle_id;
				pend_q.count  <= '0;
			end
		end else if (emit && !s1_hold) begin
			pend_q.kind   <= KIND_FIRED;
			pend_q.handle <= rd_data_s1.handle;
			pend_q.count  <= '0;
		end else if (scan_done && (op_q == REQ_REMOVE)) begin
			pend_q.kind   <= KIND_REMOVE;
			pend_q.handle <= handle_q;
			pend_q.count  <= cnt_sat;
		end
		if (push_out || flush_out) begin
			out_q      <= pend_q;
			out_last_q <= flush_out;
		end
	end

	assign out_valid     = out_vld_q;
	assign kind          = out_q.kind;
	assign fired_handle  = out_q.handle;
	assign removed_count = out_q.count;
	assign last          = out_last_q;

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_vld_q)
		else $error("pending beat left over in idle");

	a_flush_has_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> pend_vld_q)
		else $error("flush without a pending beat");

	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_s1 |-> (state_q == ST_SCAN))
		else $error("pipe stage valid outside a scan");

	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fired_n_q <= FIRE_W'(MAX_RESULTS))
		else $error("fired beat count above limit");

	a_push_frees_out: assert property (@(posedge clk) disable iff (!arst_n)
		(push_out || flush_out) |-> out_free)
		else $error("output register overwritten while stalled");

	a_hold_keeps_idx: assert property (@(posedge clk) disable iff (!arst_n)
		s1_hold |=> (s1_vld_s1 && $stable(idx_s1) && $stable(rd_idx_q)))
		else $error("scan advanced while held");

endmodule
